// ===== sv/box_blur_3x3_edge_aware_assert.svh =====
// assertion macros shared by the blur block
`ifndef BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH

`ifndef ASSERT_OFF
`define BBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BBE_ASSERT(label, prop, msg)
`define BBE_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== sv/bbe_pkg.sv =====
// shared types and constants of the blur block
`default_nettype none

package bbe_pkg;

  localparam int PIX_W    = 8;   // bits per colour channel
  localparam int CH       = 3;   // colour channels per pixel
  localparam int DIM_W    = 9;   // image dimension register width
  localparam int SUM_W    = 12;  // nine taps of 255 plus rounding term
  localparam int CNT_W    = 4;   // tap count, 1 to 9
  localparam int MAX_TAPS = 9;

  // channel positions inside a stored pixel
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLUR  = 1'b1;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] chan_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [DIM_W-1:0] dim_t;

endpackage

`default_nettype wire

// ===== sv/bbe_ram.sv =====
// generic single-port synchronous ram with registered read
`default_nettype none

module bbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bbe_div.sv =====
// small radix-4 divider for the three channel averages, shared divisor
`default_nettype none

module bbe_div
  import bbe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire sum_t  [CH-1:0]        num,
  input  wire cnt_t                  den,
  output logic                       done,
  output chan_t      [CH-1:0]        quot
);

  localparam int STEPS  = PIX_W / 2;
  localparam int STEP_W = $clog2(STEPS);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  cnt_t                      d;
  cnt_t  [CH-1:0]            rem;
  cnt_t  [CH-1:0]            rem_next;
  chan_t [CH-1:0]            sh;
  chan_t [CH-1:0]            sh_next;

  // two restoring steps per cycle; remainder stays below the divisor
  always_comb begin
    logic [CNT_W:0] t;
    cnt_t           r;
    chan_t          s;
    for (int i = 0; i < CH; i++) begin
      r = rem[i];
      s = sh[i];
      for (int k = 0; k < 2; k++) begin
        t = {r, s[PIX_W-1]};
        s = {s[PIX_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t    = t - {1'b0, d};
          s[0] = 1'b1;
        end
        r = t[CNT_W-1:0];
      end
      rem_next[i] = r;
      sh_next[i]  = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        d    <= den;
        for (int i = 0; i < CH; i++) begin
          // average fits 8 bits, so the top numerator bits are below the divisor
          rem[i] <= num[i][SUM_W-1:PIX_W];
          sh[i]  <= num[i][PIX_W-1:0];
        end
      end else if (busy) begin
        rem  <= rem_next;
        sh   <= sh_next;
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sh;

endmodule

`default_nettype wire

// ===== sv/box_blur_3x3_edge_aware.sv =====
// top level of the edge-aware 3x3 box blur over an rgb frame memory
//
// frame memory of MAX_HEIGHT x MAX_WIDTH rgb pixels, 8 bits a channel, addressed by
// row * MAX_WIDTH + col. an item with operation write stores one pixel, or is dropped
// when it lies outside the configured image; it gives no result. an item with operation
// blur returns the rounded mean, (sum + n/2) / n, of the n neighbours of the 3x3 window
// that lie inside the image (n is 1 to 9). a blur item outside the image returns zeros
// with out_of_range set; it skips the window walk and goes from idle to the emit state,
// which loads the result register. a blur inside the image keeps the block busy until
// its result is loaded: the scan state walks the nine window positions, one per cycle,
// reading those inside the image from the single-port frame memory, the drain state
// collects the last read, the shared divider works out the three channel quotients
// (two quotient bits a cycle) and the emit state loads the result register once the
// slot is free. one item is worked on at a time; the result register lets a new item
// be taken while the last result still waits on rsp_stall. the frame memory has no
// reset and needs no clearing pass: a pixel must be written before any blur reads it.
// image_width and image_height of zero act as one, values above the maximum saturate.
`default_nettype none

module box_blur_3x3_edge_aware
  import bbe_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [DIM_W-1:0]   cfg_data,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic               operation,
  input  wire logic [7:0]         row,
  input  wire logic [7:0]         col,
  input  wire logic [7:0]         red_in,
  input  wire logic [7:0]         green_in,
  input  wire logic [7:0]         blue_in,
  // result channel
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out,
  output logic                    out_of_range
);

`include "box_blur_3x3_edge_aware_assert.svh"

  localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PX_W   = CH * PIX_W;
  // a 9 bit register cannot exceed 511, so larger maxima never saturate
  localparam int W_CLIP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int H_CLIP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam dim_t W_SAT = DIM_W'(W_CLIP);
  localparam dim_t H_SAT = DIM_W'(H_CLIP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_EMIT
  } state_t;

  state_t             state;

  // configuration
  dim_t               image_width;
  dim_t               image_height;
  dim_t               eff_w;
  dim_t               eff_h;

  // request decode
  logic               req_acc;
  logic               inside_in;

  // window walk
  logic [7:0]         crow;
  logic [7:0]         ccol;
  logic [1:0]         dr;
  logic [1:0]         dc;
  dim_t               nb_row;
  dim_t               nb_col;
  logic               nb_ok;
  logic               rd_pend;
  logic               oor_req;

  // accumulation
  sum_t [CH-1:0]      sum;
  sum_t [CH-1:0]      sum_next;
  cnt_t               cnt;
  cnt_t               cnt_next;
  sum_t [CH-1:0]      div_num;

  // frame memory port
  logic               ram_en;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [PX_W-1:0]    ram_wdata;
  logic [PX_W-1:0]    ram_rdata;

  // divider
  logic               div_start;
  logic               div_done;
  chan_t [CH-1:0]     div_quot;

  function automatic logic [AW-1:0] pix_addr(input dim_t r, input dim_t c);
    pix_addr = AW'(r * MAX_WIDTH) + AW'(c);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // effective dimensions: zero acts as one, large values saturate
  always_comb begin
    if (image_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (image_width > W_SAT) begin
      eff_w = W_SAT;
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (image_height > H_SAT) begin
      eff_h = H_SAT;
    end else begin
      eff_h = image_height;
    end
  end

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign inside_in = ({1'b0, row} < eff_h) && ({1'b0, col} < eff_w);

  // neighbour position; above or left of the edge wraps to 511, never inside
  assign nb_row = {1'b0, crow} + {7'b0, dr} - DIM_W'(1);
  assign nb_col = {1'b0, ccol} + {7'b0, dc} - DIM_W'(1);
  assign nb_ok  = (nb_row < eff_h) && (nb_col < eff_w);

  // single memory port: writes while idle, window reads while scanning
  always_comb begin
    ram_wdata = {red_in, green_in, blue_in};
    if (state == S_IDLE) begin
      ram_we   = req_acc && (operation == OP_WRITE) && inside_in;
      ram_en   = ram_we;
      ram_addr = pix_addr({1'b0, row}, {1'b0, col});
    end else begin
      ram_we   = 1'b0;
      ram_en   = (state == S_SCAN) && nb_ok;
      ram_addr = pix_addr(nb_row, nb_col);
    end
  end

  // read data arrives in the cycle after its request
  always_comb begin
    cnt_next = cnt + CNT_W'(rd_pend);
    for (int i = 0; i < CH; i++) begin
      sum_next[i] = sum[i] + (rd_pend ? SUM_W'(ram_rdata[i*PIX_W +: PIX_W]) : '0);
      div_num[i]  = sum_next[i] + SUM_W'(cnt_next >> 1);
    end
  end

  // the last read lands in the drain cycle, so the divider starts from the next sums
  assign div_start = (state == S_DRAIN);

  bbe_ram #(
    .WIDTH (PX_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_next),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer, window walk, accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      oor_req   <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN) && nb_ok;
      // a result loaded in the emit state takes over the slot instead
      if (rsp_valid && !rsp_stall && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc && (operation == OP_BLUR)) begin
            crow <= row;
            ccol <= col;
            dr   <= 2'd0;
            dc   <= 2'd0;
            cnt  <= '0;
            sum  <= '0;
            if (inside_in) begin
              oor_req <= 1'b0;
              state   <= S_SCAN;
            end else begin
              oor_req <= 1'b1;
              state   <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          sum <= sum_next;
          cnt <= cnt_next;
          if (dc == 2'd2) begin
            dc <= 2'd0;
            dr <= dr + 2'd1;
            if (dr == 2'd2) begin
              state <= S_DRAIN;
            end
          end else begin
            dc <= dc + 2'd1;
          end
        end
        S_DRAIN: begin
          sum   <= sum_next;
          cnt   <= cnt_next;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // result slot is free, or is being taken at this edge
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            out_of_range <= oor_req;
            if (oor_req) begin
              red_out   <= '0;
              green_out <= '0;
              blue_out  <= '0;
            end else begin
              red_out   <= div_quot[CH_RED];
              green_out <= div_quot[CH_GREEN];
              blue_out  <= div_quot[CH_BLUE];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BBE_ASSERT(a_write_only_idle, ram_we |-> state == S_IDLE, "frame write outside idle")
  `BBE_ASSERT(a_done_in_div, div_done |-> state == S_DIV, "divider finished out of turn")
  `BBE_ASSERT(a_cnt_range, state == S_DIV |-> (cnt >= CNT_W'(1) && cnt <= CNT_W'(MAX_TAPS)),
              "tap count out of range")
  `BBE_ASSERT(a_oor_zero,
              rsp_valid && out_of_range |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0,
              "out of range result not zero")
  `BBE_ASSERT_NEVER(a_read_after_scan, rd_pend && state != S_SCAN && state != S_DRAIN,
                    "read data pending outside window walk")

endmodule

`default_nettype wire
